### src/gms_pkg.sv
// shared types and constants for the min/max height grid ground segmentation block
package gms_pkg;

  localparam int unsigned COORD_W   = 18;
  localparam int unsigned RECIP_W   = 25;
  localparam int unsigned GRID_W    = 7;
  localparam int unsigned THRESH_W  = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 25;
  localparam int unsigned Q_BITS    = 24;
  localparam int unsigned PROD_W    = COORD_W + RECIP_W + 1;
  localparam int unsigned SUM_W     = PROD_W + 1;
  localparam int unsigned GSAT_W    = 9;
  localparam int unsigned EPOCH_W   = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_IN_USE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_RECIPROCAL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_THRESHOLD = 2'd2;

  localparam logic [GRID_W-1:0]   GRID_IN_USE_RST      = 7'd64;
  localparam logic [RECIP_W-1:0]  CELL_RECIPROCAL_RST  = 25'd83886;
  localparam logic [THRESH_W-1:0] HEIGHT_THRESHOLD_RST = 18'd150;

  typedef enum logic [1:0] {
    OP_ACCUMULATE = 2'd0,
    OP_CLASSIFY   = 2'd1,
    OP_NEW_FRAME  = 2'd2
  } gms_op_e;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } gms_state_e;

  typedef struct packed {
    gms_op_e                    op;
    logic signed [COORD_W-1:0]  z;
    logic                       in_grid;
  } gms_cmd_t;

  typedef struct packed {
    logic clearing;
  } gms_status_t;

endpackage

### src/grid_min_max_ground_segmentation_core.sv
// top level of the min/max height grid ground segmentation block
//
//   channel  handshake               beat contents
//   in       in_valid_i/in_ready_o   operation_i, point_x_i, point_y_i, point_z_i
//   out      out_valid_o/out_ready_i is_ground_o, outside_grid_o
//   cfg      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// front takes one beat a cycle while not clearing and the queue has room: multiply,
// then cell index, into a 4-deep queue; back pops only in idle; classify and in-grid
// accumulate read the cell ram (classify only if in grid), then update; out-of-grid
// accumulate, new frame and unused codes skip update; after reset and after every
// 255th new frame a clearing pass writes every cell with in_ready_o low; cfg is always
// ready; a stalled result holds the back, the queue lets the front keep taking beats
module grid_min_max_ground_segmentation_core #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [1:0]                             operation_i,
  input  logic signed [gms_pkg::COORD_W-1:0]     point_x_i,
  input  logic signed [gms_pkg::COORD_W-1:0]     point_y_i,
  input  logic signed [gms_pkg::COORD_W-1:0]     point_z_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   is_ground_o,
  output logic                                   outside_grid_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [gms_pkg::CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [gms_pkg::CFG_DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned CELL_W = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int unsigned CMD_W  = $bits(gms_pkg::gms_cmd_t);
  localparam int unsigned ITEM_W = CMD_W + CELL_W;

  logic [gms_pkg::GRID_W-1:0]   grid_in_use_q;
  logic [gms_pkg::RECIP_W-1:0]  cell_reciprocal_q;
  logic [gms_pkg::THRESH_W-1:0] height_threshold_q;

  gms_pkg::gms_status_t status;
  gms_pkg::gms_cmd_t    front_cmd, back_cmd;
  logic [CELL_W-1:0]    front_cell, back_cell;
  logic                 push_valid, push_ready, pop_valid, pop_ready;
  logic [ITEM_W-1:0]    pop_item;
  logic                 cfg_write;

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_in_use_q      <= gms_pkg::GRID_IN_USE_RST;
      cell_reciprocal_q  <= gms_pkg::CELL_RECIPROCAL_RST;
      height_threshold_q <= gms_pkg::HEIGHT_THRESHOLD_RST;
    end else if (cfg_write) begin
      case (cfg_index_i)
        gms_pkg::CFG_GRID_IN_USE: begin
          grid_in_use_q <= cfg_data_i[gms_pkg::GRID_W-1:0];
        end
        gms_pkg::CFG_CELL_RECIPROCAL: begin
          cell_reciprocal_q <= cfg_data_i[gms_pkg::RECIP_W-1:0];
        end
        gms_pkg::CFG_HEIGHT_THRESHOLD: begin
          height_threshold_q <= cfg_data_i[gms_pkg::THRESH_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  gms_front #(
    .GRID_SIZE (GRID_SIZE)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .operation_i       (operation_i),
    .point_x_i         (point_x_i),
    .point_y_i         (point_y_i),
    .point_z_i         (point_z_i),
    .grid_in_use_i     (grid_in_use_q),
    .cell_reciprocal_i (cell_reciprocal_q),
    .status_i          (status),
    .push_valid_o      (push_valid),
    .push_ready_i      (push_ready),
    .cmd_o             (front_cmd),
    .cell_o            (front_cell)
  );

  gms_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (gms_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  ({front_cmd, front_cell}),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_item)
  );

  assign back_cmd  = gms_pkg::gms_cmd_t'(pop_item[ITEM_W-1:CELL_W]);
  assign back_cell = pop_item[CELL_W-1:0];

  gms_back #(
    .GRID_SIZE (GRID_SIZE)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .pop_ready_o        (pop_ready),
    .cmd_i              (back_cmd),
    .cell_i             (back_cell),
    .height_threshold_i (height_threshold_q),
    .status_o           (status),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .is_ground_o        (is_ground_o),
    .outside_grid_o     (outside_grid_o)
  );

endmodule

### src/gms_ram.sv
// generic single write port ram with registered read
module gms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/gms_fifo.sv
// small register queue between the front and back parts
module gms_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CNT_FULL);
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### src/gms_front.sv
// front part: accepts points and maps them to grid cells
module gms_front #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [1:0]                                operation_i,
  input  logic signed [gms_pkg::COORD_W-1:0]        point_x_i,
  input  logic signed [gms_pkg::COORD_W-1:0]        point_y_i,
  input  logic signed [gms_pkg::COORD_W-1:0]        point_z_i,
  input  logic [gms_pkg::GRID_W-1:0]                grid_in_use_i,
  input  logic [gms_pkg::RECIP_W-1:0]               cell_reciprocal_i,
  input  gms_pkg::gms_status_t                      status_i,
  output logic                                      push_valid_o,
  input  logic                                      push_ready_i,
  output gms_pkg::gms_cmd_t                         cmd_o,
  output logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]    cell_o
);

  localparam int unsigned IDX_W  = $clog2(GRID_SIZE);
  localparam int unsigned CELL_W = $clog2(GRID_SIZE * GRID_SIZE);
  localparam int unsigned SUM_W  = gms_pkg::SUM_W;
  localparam int unsigned Q_BITS = gms_pkg::Q_BITS;
  localparam int unsigned QUO_W  = SUM_W - Q_BITS;
  localparam int unsigned GSAT_W = gms_pkg::GSAT_W;
  localparam logic [GSAT_W-1:0] G_MAX  = GSAT_W'(GRID_SIZE);
  localparam logic [GSAT_W-1:0] G_MIN  = GSAT_W'(2);
  localparam logic [CELL_W-1:0] GRID_C = CELL_W'(GRID_SIZE);

  logic                                    s_valid_q, s_valid_d;
  gms_pkg::gms_op_e                        s_op_q;
  logic signed [gms_pkg::COORD_W-1:0]      s_z_q;
  logic signed [gms_pkg::PROD_W-1:0]       prod_x_q, prod_y_q, prod_x_d, prod_y_d;
  logic [GSAT_W-1:0]                       g_sat;
  logic signed [SUM_W-1:0]                 half_q24, sum_x, sum_y;
  logic [IDX_W:0]                          ax_x, ax_y;
  logic                                    accept;

  function automatic logic [IDX_W:0] axis_cell(logic signed [SUM_W-1:0] s,
                                               logic [GSAT_W-1:0] g);
    logic [QUO_W-1:0] q;
    logic             ok;
    logic [IDX_W-1:0] idx;
    q   = s[SUM_W-1:Q_BITS];
    idx = '0;
    if (s[SUM_W-1]) begin
      ok = (&q) && (|s[Q_BITS-1:0]);
    end else begin
      ok = (q < QUO_W'(g));
      if (ok) begin
        idx = q[IDX_W-1:0];
      end
    end
    return {ok, idx};
  endfunction

  assign in_ready_o = !status_i.clearing && (!s_valid_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // operands are the raw input ports, products land in the stage register
  assign prod_x_d = point_x_i * $signed({1'b0, cell_reciprocal_i});
  assign prod_y_d = point_y_i * $signed({1'b0, cell_reciprocal_i});

  always_comb begin
    g_sat = {{(GSAT_W - gms_pkg::GRID_W){1'b0}}, grid_in_use_i};
    if (g_sat < G_MIN) begin
      g_sat = G_MIN;
    end else if (g_sat > G_MAX) begin
      g_sat = G_MAX;
    end
  end

  assign half_q24 = $signed(SUM_W'(g_sat >> 1) << Q_BITS);
  assign sum_x    = half_q24 + SUM_W'(prod_x_q);
  assign sum_y    = half_q24 + SUM_W'(prod_y_q);
  assign ax_x     = axis_cell(sum_x, g_sat);
  assign ax_y     = axis_cell(sum_y, g_sat);

  assign push_valid_o  = s_valid_q;
  assign cmd_o.op      = s_op_q;
  assign cmd_o.z       = s_z_q;
  assign cmd_o.in_grid = ax_x[IDX_W] && ax_y[IDX_W];
  assign cell_o        = CELL_W'(CELL_W'(ax_x[IDX_W-1:0]) * GRID_C) + CELL_W'(ax_y[IDX_W-1:0]);

  always_comb begin
    s_valid_d = s_valid_q;
    if (accept) begin
      s_valid_d = 1'b1;
    end else if (push_ready_i) begin
      s_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else begin
      s_valid_q <= s_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_op_q   <= gms_pkg::gms_op_e'(operation_i);
      s_z_q    <= point_z_i;
      prod_x_q <= prod_x_d;
      prod_y_q <= prod_y_d;
    end
  end

endmodule

### src/gms_back.sv
// back part: cell memory read-modify-write, frame epochs and classification
module gms_back #(
  parameter int unsigned GRID_SIZE = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      pop_valid_i,
  output logic                                      pop_ready_o,
  input  gms_pkg::gms_cmd_t                         cmd_i,
  input  logic [$clog2(GRID_SIZE*GRID_SIZE)-1:0]    cell_i,
  input  logic [gms_pkg::THRESH_W-1:0]              height_threshold_i,
  output gms_pkg::gms_status_t                      status_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic                                      is_ground_o,
  output logic                                      outside_grid_o
);

  localparam int unsigned CELL_COUNT = GRID_SIZE * GRID_SIZE;
  localparam int unsigned CELL_W     = $clog2(CELL_COUNT);
  localparam int unsigned Z_W        = gms_pkg::COORD_W;
  localparam int unsigned EPOCH_W    = gms_pkg::EPOCH_W;
  localparam int unsigned WORD_W     = EPOCH_W + 2 * Z_W;
  localparam logic [CELL_W-1:0]  CELL_LAST = CELL_W'(CELL_COUNT - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);

  gms_pkg::gms_state_e           state_q, state_d;
  logic [CELL_W-1:0]             clr_cnt_q, clr_cnt_d;
  logic [EPOCH_W-1:0]            epoch_q, epoch_d;
  gms_pkg::gms_cmd_t             work_q, work_d;
  logic [CELL_W-1:0]             cell_q, cell_d;
  logic                          out_valid_q, out_valid_d;
  logic                          is_ground_q, is_ground_d;
  logic                          outside_q, outside_d;

  logic                          ram_we, ram_re;
  logic [CELL_W-1:0]             ram_waddr;
  logic [WORD_W-1:0]             ram_wdata, ram_rdata;
  logic [EPOCH_W-1:0]            rd_tag;
  logic signed [Z_W-1:0]         rd_high, rd_low, new_high, new_low;
  logic signed [Z_W:0]           spread;
  logic                          seen, out_free;

  gms_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CELL_COUNT)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cell_i),
    .rdata_o (ram_rdata)
  );

  assign rd_tag   = ram_rdata[WORD_W-1 -: EPOCH_W];
  assign rd_high  = $signed(ram_rdata[2*Z_W-1 -: Z_W]);
  assign rd_low   = $signed(ram_rdata[Z_W-1:0]);
  assign seen     = work_q.in_grid && (rd_tag == epoch_q);
  assign new_low  = (!seen || (work_q.z < rd_low))  ? work_q.z : rd_low;
  assign new_high = (!seen || (work_q.z > rd_high)) ? work_q.z : rd_high;
  assign spread   = {rd_high[Z_W-1], rd_high} - {rd_low[Z_W-1], rd_low};
  assign out_free = !out_valid_q || out_ready_i;

  assign status_o.clearing = (state_q == gms_pkg::ST_CLEAR);
  assign out_valid_o       = out_valid_q;
  assign is_ground_o       = is_ground_q;
  assign outside_grid_o    = outside_q;

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    epoch_d     = epoch_q;
    work_d      = work_q;
    cell_d      = cell_q;
    out_valid_d = out_valid_q;
    is_ground_d = is_ground_q;
    outside_d   = outside_q;
    pop_ready_o = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = cell_q;
    ram_wdata   = {epoch_q, new_high, new_low};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      gms_pkg::ST_CLEAR: begin
        // tag zero never matches a live epoch
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == CELL_LAST) begin
          clr_cnt_d = '0;
          state_d   = gms_pkg::ST_IDLE;
        end
      end
      gms_pkg::ST_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          work_d = cmd_i;
          cell_d = cell_i;
          case (cmd_i.op)
            gms_pkg::OP_NEW_FRAME: begin
              if (epoch_q == EPOCH_MAX) begin
                epoch_d = EPOCH_ONE;
                state_d = gms_pkg::ST_CLEAR;
              end else begin
                epoch_d = epoch_q + 1'b1;
              end
            end
            gms_pkg::OP_ACCUMULATE: begin
              if (cmd_i.in_grid) begin
                ram_re  = 1'b1;
                state_d = gms_pkg::ST_UPDATE;
              end
            end
            gms_pkg::OP_CLASSIFY: begin
              ram_re  = cmd_i.in_grid;
              state_d = gms_pkg::ST_UPDATE;
            end
            default: begin
            end
          endcase
        end
      end
      gms_pkg::ST_UPDATE: begin
        case (work_q.op)
          gms_pkg::OP_ACCUMULATE: begin
            ram_we  = 1'b1;
            state_d = gms_pkg::ST_IDLE;
          end
          gms_pkg::OP_CLASSIFY: begin
            if (out_free) begin
              out_valid_d = 1'b1;
              is_ground_d = seen &&
                            (spread[Z_W:0] < {1'b0, height_threshold_i});
              outside_d   = !work_q.in_grid;
              state_d     = gms_pkg::ST_IDLE;
            end
          end
          default: begin
            state_d = gms_pkg::ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = gms_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gms_pkg::ST_CLEAR;
      clr_cnt_q   <= '0;
      epoch_q     <= EPOCH_ONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      epoch_q     <= epoch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q      <= work_d;
    cell_q      <= cell_d;
    is_ground_q <= is_ground_d;
    outside_q   <= outside_d;
  end

endmodule
